>>> design/hrc_pkg.sv
// Shared types, codes and the popcount function of the Hamming matcher.
`timescale 1ns / 1ps
package hrc_pkg;

  // Row index width on the ports; stores never exceed 64 rows
  localparam int IDX_W = 6;
  localparam int WORD_W = 64;
  localparam int CNT_PORT_W = 7;
  localparam logic [6:0] NO_MATCH = 7'h7F;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    REG_RATIO = 1'b0,
    REG_XCHK  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIX_RD,
    S_STREAM,
    S_DRAIN,
    S_DECIDE,
    S_OUT_RD,
    S_OUT_CHK,
    S_OUT_EMIT
  } state_t;

  // Side band that rides along with each candidate row through the chain
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } hrc_tag_t;

  // SWAR population count of one 64-bit word
  function automatic logic [6:0] popcnt64(input logic [63:0] x);
    logic [63:0] c;
    c = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    c = (c & 64'h3333_3333_3333_3333) + ((c >> 2) & 64'h3333_3333_3333_3333);
    c = (c + (c >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    c = c + (c >> 8);
    c = c + (c >> 16);
    c = c + (c >> 32);
    return c[6:0];
  endfunction

endpackage

>>> design/hrc_cell.sv
// One distance cell: adds the popcount of one word pair and shifts the row on.
`timescale 1ns / 1ps
module hrc_cell #(
  parameter int ROW_W  = 256,
  parameter int DIST_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        fixed_word,
  input  logic [ROW_W-1:0]   row_in,
  input  logic [DIST_W-1:0]  sum_in,
  input  hrc_pkg::hrc_tag_t  tag_in,
  output logic [ROW_W-1:0]   row_out,
  output logic [DIST_W-1:0]  sum_out,
  output hrc_pkg::hrc_tag_t  tag_out
);
  import hrc_pkg::*;

  logic [ROW_W-1:0]  row_r;
  logic [DIST_W-1:0] sum_r;
  hrc_tag_t          tag_r;

  // the whole tag is reset as control; row and sum are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  // lowest word is consumed here, the next cell sees the following word
  always_ff @(posedge clk) begin
    row_r <= row_in >> WORD_W;
    sum_r <= sum_in + DIST_W'(popcnt64(fixed_word ^ row_in[63:0]));
  end

  assign row_out = row_r;
  assign sum_out = sum_r;
  assign tag_out = tag_r;

endmodule

>>> design/hrc_top2.sv
// Tracks the nearest and second nearest distance over one candidate sweep.
`timescale 1ns / 1ps
module hrc_top2 #(
  parameter int DIST_W = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  hrc_pkg::hrc_tag_t     tag_in,
  input  logic [DIST_W-1:0]     dist_in,
  output logic [hrc_pkg::IDX_W-1:0] best_idx,
  output logic [DIST_W:0]       best,
  output logic [DIST_W:0]       second,
  output logic                  done
);
  import hrc_pkg::*;

  logic [DIST_W:0]  best_r, best_nxt, second_r, second_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             done_r;
  logic [DIST_W:0]  d;

  assign d = {1'b0, dist_in};

  // insert one distance; lower index wins ties since only strict less moves
  always_comb begin
    best_nxt   = best_r;
    second_nxt = second_r;
    idx_nxt    = idx_r;
    priority if (d < best_r) begin
      second_nxt = best_r;
      best_nxt   = d;
      idx_nxt    = tag_in.idx;
    end else if (d < second_r) begin
      second_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (clr) begin
      done_r <= 1'b0;
    end else if (tag_in.valid) begin
      done_r <= tag_in.last;
    end
  end

  // all ones sits above every real distance
  always_ff @(posedge clk) begin
    if (clr) begin
      best_r   <= '1;
      second_r <= '1;
      idx_r    <= '0;
    end else if (tag_in.valid) begin
      best_r   <= best_nxt;
      second_r <= second_nxt;
      idx_r    <= idx_nxt;
    end
  end

  assign best_idx = idx_r;
  assign best     = best_r;
  assign second   = second_r;
  assign done     = done_r;

endmodule

>>> design/hamming_ratio_crosscheck_matcher_unit.sv
// Top level: descriptor stores, sweep sequencer, distance cell chain, result port.
//
//  channel | dir | tdata / fields                                  | tuser / tlast
//  in_     | in  | row_index, desc_w0..3, count_a, count_b (280 b) | op
//  out_    | out | a_index, match_index, match_count (24 b)        | tlast = is_last
//  cfg_    | in  | cfg_index selects ratio_q8 / cross_check_enable | -
//
// Loads are taken back to back while idle. A compute reads each fixed row once and
// streams the other set through the DESC_WORDS-cell chain one row per cycle, forward
// and, with cross check on, in reverse; each result is then read, checked and sent.
// The single read port of each store sets this order.
// Reset is synchronous and clears control only; stores hold garbage until loaded.
// in_tready is low through a compute; a stalled result holds the sequencer.
`timescale 1ns / 1ps
module hamming_ratio_crosscheck_matcher_unit #(
  parameter int MAX_ROWS   = 64,
  parameter int DESC_WORDS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  // [5:0] row_index, [69:6] desc_w0, [133:70] desc_w1, [197:134] desc_w2,
  // [261:198] desc_w3, [268:262] count_a, [275:269] count_b, [279:276] zero
  input  logic [279:0] in_tdata,
  // [1:0] op
  input  logic [1:0]   in_tuser,
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] a_index, [12:6] match_index, [19:13] match_count, [23:20] zero
  output logic [23:0]  out_tdata,
  output logic         out_tlast,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [8:0]   cfg_data
);
  import hrc_pkg::*;

  localparam int ROW_W  = DESC_WORDS * WORD_W;
  localparam int DIST_W = $clog2(ROW_W + 1);
  localparam int AW     = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam logic [6:0] MAX_CNT = 7'(MAX_ROWS);

  // configuration
  logic [8:0] ratio_r;
  logic       xchk_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= 9'd192;
      xchk_r  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RATIO: ratio_r <= cfg_data;
        REG_XCHK:  xchk_r  <= cfg_data[0];
        default:   ratio_r <= ratio_r;
      endcase
    end
  end

  // input fields
  logic [5:0]       f_row;
  logic [ROW_W-1:0] f_desc;
  logic [6:0]       f_cnt_a, f_cnt_b;
  logic [CNT_W-1:0] sat_a, sat_b;

  assign f_row   = in_tdata[5:0];
  assign f_desc  = in_tdata[6 +: ROW_W];
  assign f_cnt_a = in_tdata[268:262];
  assign f_cnt_b = in_tdata[275:269];
  assign sat_a   = (f_cnt_a > MAX_CNT) ? CNT_W'(MAX_ROWS) : f_cnt_a[CNT_W-1:0];
  assign sat_b   = (f_cnt_b > MAX_CNT) ? CNT_W'(MAX_ROWS) : f_cnt_b[CNT_W-1:0];

  // sequencer state
  state_t           state_r, state_nxt;
  logic             pass_r;
  logic [CNT_W-1:0] na_r, nb_r, outer_r, inner_r;
  logic [6:0]       count_r;

  logic [CNT_W-1:0] nq, nt;
  assign nq = pass_r ? nb_r : na_r;
  assign nt = pass_r ? na_r : nb_r;

  logic in_acc, load_ok;
  assign in_acc  = in_tvalid && in_tready;
  assign load_ok = ({1'b0, f_row} < MAX_CNT);

  // stores
  logic [ROW_W-1:0] qmem [MAX_ROWS];
  logic [ROW_W-1:0] tmem [MAX_ROWS];
  logic [6:0]       fmem [MAX_ROWS];
  logic [6:0]       rmem [MAX_ROWS];
  logic [ROW_W-1:0] q_rd_r, t_rd_r;
  logic [6:0]       f_rd_r, r_rd_r;

  // control decoded from state
  logic             q_rd_en, t_rd_en, f_rd_en, r_rd_en, tr_clr, issue, dec_wr, emit;
  logic [AW-1:0]    q_rd_addr, t_rd_addr, r_rd_addr;
  hrc_tag_t         issue_tag;

  // chain signals
  logic [ROW_W-1:0]  row_c [DESC_WORDS+1];
  logic [DIST_W-1:0] sum_c [DESC_WORDS+1];
  hrc_tag_t          tag_c [DESC_WORDS+1];
  logic [ROW_W-1:0]  fixed_row;

  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W:0]   best, second;
  logic              tr_done;

  // ratio test
  logic [DIST_W+8:0] lhs, rhs;
  logic              accept;
  logic [6:0]        dec_res;
  assign lhs     = {best, 8'b0};
  assign rhs     = second * ratio_r;
  assign accept  = (nt >= CNT_W'(2)) && (lhs < rhs);
  assign dec_res = accept ? 7'(best_idx) : NO_MATCH;

  // output decision
  logic       keep, out_free, last_out, last_q, last_t;
  logic [6:0] count_nxt;
  assign out_free  = !out_tvalid || out_tready;
  assign keep      = (f_rd_r != NO_MATCH) &&
                     (!xchk_r || ((f_rd_r < 7'(nb_r)) && (r_rd_r == 7'(outer_r))));
  assign count_nxt = count_r + 7'(keep);
  assign last_out  = (outer_r == na_r - CNT_W'(1));
  assign last_q    = (outer_r == nq - CNT_W'(1));
  assign last_t    = (inner_r == nt - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:
        if (in_acc && (op_t'(in_tuser) == OP_COMPUTE) && (sat_a != '0)) begin
          state_nxt = S_FIX_RD;
        end
      S_FIX_RD:  state_nxt = S_STREAM;
      S_STREAM:
        if (nt == '0) begin
          state_nxt = S_DECIDE;
        end else if (last_t) begin
          state_nxt = S_DRAIN;
        end
      S_DRAIN:
        if (tr_done) begin
          state_nxt = S_DECIDE;
        end
      S_DECIDE:
        if (!last_q) begin
          state_nxt = S_FIX_RD;
        end else if (!pass_r && xchk_r && (nb_r != '0)) begin
          state_nxt = S_FIX_RD;
        end else begin
          state_nxt = S_OUT_RD;
        end
      S_OUT_RD:  state_nxt = S_OUT_CHK;
      S_OUT_CHK: state_nxt = S_OUT_EMIT;
      S_OUT_EMIT:
        if (out_free) begin
          state_nxt = last_out ? S_IDLE : S_OUT_RD;
        end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_rd_en   = 1'b0;
    t_rd_en   = 1'b0;
    f_rd_en   = 1'b0;
    r_rd_en   = 1'b0;
    tr_clr    = 1'b0;
    issue     = 1'b0;
    dec_wr    = 1'b0;
    emit      = 1'b0;
    q_rd_addr = pass_r ? inner_r[AW-1:0] : outer_r[AW-1:0];
    t_rd_addr = pass_r ? outer_r[AW-1:0] : inner_r[AW-1:0];
    r_rd_addr = f_rd_r[AW-1:0];
    unique case (state_r)
      S_FIX_RD: begin
        tr_clr  = 1'b1;
        q_rd_en = !pass_r;
        t_rd_en = pass_r;
      end
      S_STREAM: begin
        issue   = (nt != '0);
        q_rd_en = pass_r && issue;
        t_rd_en = !pass_r && issue;
      end
      S_DECIDE:   dec_wr  = 1'b1;
      S_OUT_RD:   f_rd_en = 1'b1;
      S_OUT_CHK:  r_rd_en = 1'b1;
      S_OUT_EMIT: emit    = out_free;
      default: ;
    endcase
  end

  assign issue_tag.valid = issue;
  assign issue_tag.last  = last_t;
  assign issue_tag.idx   = IDX_W'(inner_r);

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
      outer_r <= '0;
      inner_r <= '0;
      na_r    <= '0;
      nb_r    <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          na_r    <= sat_a;
          nb_r    <= sat_b;
          pass_r  <= 1'b0;
          outer_r <= '0;
          count_r <= '0;
        end
        S_FIX_RD: inner_r <= '0;
        S_STREAM: inner_r <= inner_r + CNT_W'(issue);
        S_DECIDE:
          if (last_q) begin
            outer_r <= '0;
            pass_r  <= 1'b1;
          end else begin
            outer_r <= outer_r + CNT_W'(1);
          end
        S_OUT_EMIT:
          if (out_free) begin
            outer_r <= outer_r + CNT_W'(1);
            count_r <= count_nxt;
          end
        default: ;
      endcase
    end
  end

  // store access
  always_ff @(posedge clk) begin
    if (in_acc && load_ok && (op_t'(in_tuser) == OP_LOAD_A)) begin
      qmem[f_row[AW-1:0]] <= f_desc;
    end
    if (in_acc && load_ok && (op_t'(in_tuser) == OP_LOAD_B)) begin
      tmem[f_row[AW-1:0]] <= f_desc;
    end
    if (q_rd_en) begin
      q_rd_r <= qmem[q_rd_addr];
    end
    if (t_rd_en) begin
      t_rd_r <= tmem[t_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dec_wr && !pass_r) begin
      fmem[outer_r[AW-1:0]] <= dec_res;
    end
    if (dec_wr && pass_r) begin
      rmem[outer_r[AW-1:0]] <= dec_res;
    end
    if (f_rd_en) begin
      f_rd_r <= fmem[outer_r[AW-1:0]];
    end
    if (r_rd_en) begin
      r_rd_r <= rmem[r_rd_addr];
    end
  end

  // tag follows the store read latency into the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c[0] <= '0;
    end else begin
      tag_c[0] <= issue_tag;
    end
  end

  assign fixed_row = pass_r ? t_rd_r : q_rd_r;
  assign row_c[0]  = pass_r ? q_rd_r : t_rd_r;
  assign sum_c[0]  = '0;

  // distance chain, one cell per descriptor word
  for (genvar w = 0; w < DESC_WORDS; w++) begin : g_cell
    hrc_cell #(
      .ROW_W  (ROW_W),
      .DIST_W (DIST_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .fixed_word (fixed_row[w*WORD_W +: WORD_W]),
      .row_in     (row_c[w]),
      .sum_in     (sum_c[w]),
      .tag_in     (tag_c[w]),
      .row_out    (row_c[w+1]),
      .sum_out    (sum_c[w+1]),
      .tag_out    (tag_c[w+1])
    );
  end

  hrc_top2 #(
    .DIST_W (DIST_W)
  ) u_top2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (tr_clr),
    .tag_in   (tag_c[DESC_WORDS]),
    .dist_in  (sum_c[DESC_WORDS]),
    .best_idx (best_idx),
    .best     (best),
    .second   (second),
    .done     (tr_done)
  );

  // result register
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {4'b0, (last_out ? count_nxt : 7'd0),
                     (keep ? f_rd_r : NO_MATCH), 6'(outer_r)};
      out_last_r <= last_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign in_tready  = (state_r == S_IDLE);

endmodule

>>> design/hrc_checker.sv
// Port-level checks on the matcher, bound to the top level.
`timescale 1ns / 1ps
module hrc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [279:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata,
  input logic         out_tlast
);
  import hrc_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a compute with rows blocks further input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_COMPUTE) && (in_tdata[268:262] != 7'd0)
    |=> !in_tready)
    else $error("input taken during compute");

  // count only appears on the closing beat
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[19:13] == 7'd0))
    else $error("count outside last beat");

  // count never exceeds the number of rows reported
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> ({1'b0, out_tdata[19:13]} <= {2'b0, out_tdata[5:0]} + 8'd1))
    else $error("match count too large");

  // results are only produced while input is held off
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without compute");

endmodule

bind hamming_ratio_crosscheck_matcher_unit hrc_checker u_hrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
